### hw/rtl/ici_pkg.sv
// ----------------------------------------------------------------------------
// ici_pkg
// Shared types and constants of the interval clock with interrupt.
// ----------------------------------------------------------------------------
package ici_pkg;

    // Width of the period counter (tick count); reads return its low 16 bits.
    localparam int COUNT_WIDTH = 16;

    // One minute in milliseconds; the period is MINUTE_MS / rate.
    localparam logic [15:0] MINUTE_MS = 16'd60000;

    // Item kinds.
    localparam logic [1:0] OP_CMD  = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_POLL = 2'd2;

    // Hardware command codes.
    localparam logic [15:0] CMD_SET_RATE = 16'd0;
    localparam logic [15:0] CMD_READ     = 16'd1;
    localparam logic [15:0] CMD_SET_MSG  = 16'd2;

    typedef struct packed {
        logic        read_valid;
        logic [15:0] read_value;
        logic        irq_valid;
        logic [15:0] irq_message;
    } t_result;

    typedef struct packed {
        logic        start;
        logic [15:0] divisor;
    } t_div_ctrl;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] quotient;
    } t_div_stat;

endpackage

### hw/rtl/interval_clock_interrupt_top.sv
// ----------------------------------------------------------------------------
// interval_clock_interrupt_top
// Programmable interval clock with interrupt, driven by command, tick and
// poll beats, with one result beat per input beat.
// ----------------------------------------------------------------------------
// Each input beat yields exactly one output beat, in order. A tick, a poll or
// any command other than a nonzero rate set passes through the idle and result
// states; a rate set with a nonzero rate also waits in the divide state for the
// 16-step bit-serial divider that computes the period as 60000 / rate
// milliseconds. An output register holds a finished beat, so the core can take
// and finish one further input beat while the output side is stalled.
module interval_clock_interrupt_top
    import ici_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // reg_a [15:0], reg_b [31:16]
    input  logic [1:0]  s_axis_tuser,  // op [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // read_value [15:0], irq_message [31:16]
    output logic [1:0]  m_axis_tuser   // read_valid [0], irq_valid [1]
);

    logic    res_valid;
    logic    res_ready;
    t_result res;

    logic    r_out_valid;
    t_result r_out;

    ici_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_reg_a     (s_axis_tdata[15:0]),
        .i_reg_b     (s_axis_tdata[31:16]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.irq_message, r_out.read_value};
    assign m_axis_tuser  = {r_out.irq_valid, r_out.read_valid};

endmodule

### hw/rtl/ici_divider.sv
// ----------------------------------------------------------------------------
// ici_divider
// Bit-serial restoring divider that computes MINUTE_MS / divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module ici_divider
    import ici_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_ctrl i_ctrl,
    output t_div_stat o_stat
);

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [15:0] r_dvd;
    logic [15:0] r_dsr;
    logic [15:0] r_rem;
    logic [15:0] r_quo;

    logic [16:0] rem_sh;
    logic [16:0] rem_sub;
    logic        q_bit;

    // The partial remainder stays below the divisor, so 17 bits hold the shift.
    assign rem_sh  = {r_rem, r_dvd[15]};
    assign q_bit   = (rem_sh >= {1'b0, r_dsr});
    assign rem_sub = rem_sh - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_dvd <= MINUTE_MS;
            r_dsr <= i_ctrl.divisor;
            r_rem <= 16'd0;
            r_quo <= 16'd0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[14:0], 1'b0};
            r_rem <= q_bit ? rem_sub[15:0] : rem_sh[15:0];
            r_quo <= {r_quo[14:0], q_bit};
        end
    end

    assign o_stat.busy     = r_busy;
    assign o_stat.done     = r_done;
    assign o_stat.quotient = r_quo;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider finished without running");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider flags done while still running");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |-> !r_busy)
        else $error("divider restarted while running");

endmodule

### hw/rtl/ici_core.sv
// ----------------------------------------------------------------------------
// ici_core
// Clock state and item sequencer: decodes commands, ticks and polls, starts
// the serial divider on a rate set and holds one result until handed off.
// ----------------------------------------------------------------------------
module ici_core
    import ici_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_reg_a,
    input  logic [15:0] i_reg_b,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output t_result     o_res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_RES  = 2'd2;

    logic [1:0]             r_state,   n_state;
    logic [15:0]            r_rate,    n_rate;
    logic [15:0]            r_period,  n_period;
    logic [15:0]            r_phase,   n_phase;
    logic [COUNT_WIDTH-1:0] r_ticks,   n_ticks;
    logic [15:0]            r_msg,     n_msg;
    logic                   r_pending, n_pending;
    t_result                r_res,     n_res;

    logic [15:0] phase_inc;
    t_div_ctrl   div_ctrl;
    t_div_stat   div_stat;

    ici_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (div_ctrl),
        .o_stat  (div_stat)
    );

    assign phase_inc = r_phase + 16'd1;

    always_comb begin
        n_state          = r_state;
        n_rate           = r_rate;
        n_period         = r_period;
        n_phase          = r_phase;
        n_ticks          = r_ticks;
        n_msg            = r_msg;
        n_pending        = r_pending;
        n_res            = r_res;
        div_ctrl.start   = 1'b0;
        div_ctrl.divisor = i_reg_b;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_res   = '0;
                    n_state = ST_RES;
                    case (i_op)
                        OP_CMD: begin
                            case (i_reg_a)
                                CMD_SET_RATE: begin
                                    n_rate  = i_reg_b;
                                    n_phase = 16'd0;
                                    n_ticks = '0;
                                    // A zero rate stops the clock and keeps the old period.
                                    if (i_reg_b != 16'd0) begin
                                        div_ctrl.start = 1'b1;
                                        n_state        = ST_DIV;
                                    end
                                end
                                CMD_READ: begin
                                    n_res.read_valid = 1'b1;
                                    n_res.read_value = r_ticks[15:0];
                                end
                                CMD_SET_MSG: begin
                                    n_msg = i_reg_b;
                                end
                                default: begin
                                end
                            endcase
                        end
                        OP_TICK: begin
                            if (r_rate != 16'd0) begin
                                if (phase_inc >= r_period) begin
                                    n_phase   = 16'd0;
                                    n_ticks   = r_ticks + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
                                    n_pending = (r_msg != 16'd0);
                                end else begin
                                    n_phase = phase_inc;
                                end
                            end
                        end
                        OP_POLL: begin
                            // A message cleared while pending leaves the pending bit set.
                            if (r_pending && (r_msg != 16'd0)) begin
                                n_pending         = 1'b0;
                                n_res.irq_valid   = 1'b1;
                                n_res.irq_message = r_msg;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    // Rates above 60000 give a zero quotient; the period
                    // is held at one millisecond.
                    n_period = (div_stat.quotient == 16'd0) ? 16'd1 : div_stat.quotient;
                    n_state  = ST_RES;
                end
            end
            ST_RES: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rate    <= 16'd0;
            r_period  <= 16'd0;
            r_phase   <= 16'd0;
            r_ticks   <= '0;
            r_msg     <= 16'd0;
            r_pending <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rate    <= n_rate;
            r_period  <= n_period;
            r_phase   <= n_phase;
            r_ticks   <= n_ticks;
            r_msg     <= n_msg;
            r_pending <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_RES);
    assign o_res       = r_res;

    a_period_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_IDLE) && (r_rate != 16'd0)) |-> (r_period != 16'd0))
        else $error("running clock has a zero period");

    a_div_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (div_stat.busy || div_stat.done))
        else $error("waiting on a divider that is not running");

    a_irq_message: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RES) && r_res.irq_valid) |-> (r_res.irq_message != 16'd0))
        else $error("interrupt delivered with a zero message");

endmodule

### bench/interval_clock_interrupt_top_test.sv
// ----------------------------------------------------------------------------
// interval_clock_interrupt_top_test
// Self-checking bench for the interval clock with interrupt. A behavioral
// copy of the clock predicts the result beat of every accepted input beat;
// directed cases cover the reset state, rate extremes, interrupts and ignored beats, then
// random traffic, an output stall and a run of one-millisecond periods.
// ----------------------------------------------------------------------------
module interval_clock_interrupt_top_test
    import ici_pkg::*;
();

    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam logic [15:0] CMD_UNUSED  = 16'hFFFF;
    localparam int          DRAIN_LIMIT = 200000;
    localparam int          TAIL_CYCLES = 40;
    localparam int          HOLD_CYCLES = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // reg_a [15:0], reg_b [31:16]
    logic [1:0]  s_axis_tuser;   // op [1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // read_value [15:0], irq_message [31:16]
    logic [1:0]  m_axis_tuser;   // read_valid [0], irq_valid [1]

    // Behavioral copy of the clock state.
    logic [15:0]            clk_rate;
    logic [15:0]            clk_period;
    logic [15:0]            clk_phase;
    logic [COUNT_WIDTH-1:0] clk_ticks;
    logic [15:0]            clk_message;
    logic                   clk_pending;

    t_result clock_results[$];
    t_result next_result;
    int      error_count;
    int      hold_cycles;
    bit      send_idle_on;
    bit      recv_idle_on;

    interval_clock_interrupt_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #50000000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] expected,
                                   input logic [31:0] actual);
        $display("mismatch on %s: expected %0h, got %0h at %0t", what, expected, actual,
                 $realtime);
        error_count++;
    endtask

    task automatic advance_clock(input logic [1:0] op, input logic [15:0] code,
                                 input logic [15:0] arg, output t_result res);
        logic [15:0] quot;
        res = '0;
        case (op)
            OP_CMD: begin
                if (code == CMD_SET_RATE) begin
                    clk_rate = arg;
                    // A rate of zero stops the clock but keeps the old period.
                    if (arg != 16'd0) begin
                        quot = MINUTE_MS / arg;
                        clk_period = (quot == 16'd0) ? 16'd1 : quot;
                    end
                    clk_phase = '0;
                    clk_ticks = '0;
                end else if (code == CMD_READ) begin
                    res.read_valid = 1'b1;
                    res.read_value = clk_ticks[15:0];
                end else if (code == CMD_SET_MSG) begin
                    clk_message = arg;
                end
            end
            OP_TICK: begin
                if (clk_rate != 16'd0) begin
                    clk_phase = clk_phase + 16'd1;
                    if (clk_phase >= clk_period) begin
                        clk_phase   = '0;
                        clk_ticks   = clk_ticks + COUNT_WIDTH'(1);
                        clk_pending = (clk_message != 16'd0);
                    end
                end
            end
            OP_POLL: begin
                // A pending interrupt with a cleared message stays pending.
                if (clk_pending && clk_message != 16'd0) begin
                    clk_pending     = 1'b0;
                    res.irq_valid   = 1'b1;
                    res.irq_message = clk_message;
                end
            end
            default: ;
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    // with tvalid still high, so the next call assigns it only once.
    task automatic send_item(input logic [1:0] op, input logic [15:0] code,
                             input logic [15:0] arg);
        t_result res;
        while (send_idle_on && $urandom_range(0, 99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {arg, code};
        do @(posedge i_clk); while (!s_axis_tready);
        advance_clock(op, code, arg, res);
        clock_results.push_back(res);
        @(negedge i_clk);
    endtask

    task automatic send_random_item();
        int          pick;
        logic [15:0] arg;
        pick = $urandom_range(0, 99);
        arg  = 16'($urandom);
        if (pick < 55) begin
            send_item(OP_TICK, 16'($urandom), arg);
        end else if (pick < 70) begin
            send_item(OP_POLL, 16'($urandom), arg);
        end else if (pick < 78) begin
            // Mostly fast rates, so that periods end within a few ticks.
            case ($urandom_range(0, 19))
                0:       arg = 16'd0;
                1, 2:    ;
                default: arg = 16'($urandom_range(3000, 65535));
            endcase
            send_item(OP_CMD, CMD_SET_RATE, arg);
        end else if (pick < 86) begin
            send_item(OP_CMD, CMD_READ, arg);
        end else if (pick < 92) begin
            if ($urandom_range(0, 3) == 0) arg = 16'd0;
            send_item(OP_CMD, CMD_SET_MSG, arg);
        end else if (pick < 96) begin
            send_item(OP_CMD, 16'($urandom_range(3, 65535)), arg);
        end else begin
            send_item(OP_UNUSED, 16'($urandom), arg);
        end
    endtask

    task automatic test_reset_state();
        send_item(OP_CMD, CMD_READ, 16'd0);
        send_item(OP_POLL, 16'd0, 16'd0);
    endtask

    task automatic test_rate_extremes();
        send_item(OP_CMD, CMD_SET_RATE, 16'd60000);
        send_item(OP_TICK, 16'd0, 16'd0);
        send_item(OP_TICK, 16'hFFFF, 16'hFFFF);
        send_item(OP_CMD, CMD_READ, 16'hFFFF);
        // Above 60000 the period is clamped to one millisecond.
        send_item(OP_CMD, CMD_SET_RATE, 16'hFFFF);
        send_item(OP_TICK, 16'd0, 16'd0);
        send_item(OP_CMD, CMD_READ, 16'd0);
        send_item(OP_CMD, CMD_SET_RATE, 16'd0);
        send_item(OP_TICK, 16'd0, 16'd0);
        send_item(OP_CMD, CMD_READ, 16'd0);
    endtask

    task automatic test_interrupts();
        send_item(OP_CMD, CMD_SET_MSG, 16'hFFFF);
        send_item(OP_CMD, CMD_SET_RATE, 16'd60000);
        send_item(OP_TICK, 16'd0, 16'd0);
        send_item(OP_POLL, 16'd0, 16'd0);
        send_item(OP_POLL, 16'd0, 16'd0);
        send_item(OP_TICK, 16'd0, 16'd0);
        // A rate set leaves the pending interrupt in place.
        send_item(OP_CMD, CMD_SET_RATE, 16'd30000);
        send_item(OP_POLL, 16'd0, 16'd0);
        send_item(OP_TICK, 16'd0, 16'd0);
        send_item(OP_TICK, 16'd0, 16'd0);
        send_item(OP_CMD, CMD_SET_MSG, 16'd0);
        send_item(OP_POLL, 16'd0, 16'd0);
        send_item(OP_CMD, CMD_SET_MSG, 16'd1);
        send_item(OP_POLL, 16'd0, 16'd0);
    endtask

    task automatic test_ignored_items();
        send_item(OP_CMD, CMD_UNUSED, 16'hFFFF);
        send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_random_traffic();
        repeat (600) send_random_item();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        repeat (300) send_random_item();
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        repeat (600) send_random_item();
    endtask

    // The receiver stops while beats keep coming, so the input must stall.
    task automatic test_back_pressure();
        hold_cycles = HOLD_CYCLES;
        repeat (40) send_random_item();
    endtask

    // Period of one millisecond, so every tick ends a period.
    task automatic test_tick_count();
        send_item(OP_CMD, CMD_SET_RATE, 16'd60000);
        repeat (30) send_item(OP_TICK, 16'd0, 16'd0);
        send_item(OP_CMD, CMD_READ, 16'd0);
        send_item(OP_POLL, 16'd0, 16'd0);
    endtask

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            m_axis_tready <= !(recv_idle_on && $urandom_range(0, 99) < 9);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (clock_results.size() == 0) begin
                report_mismatch("unexpected beat", '0, m_axis_tdata);
            end else begin
                next_result = clock_results.pop_front();
                if (m_axis_tuser[0] !== next_result.read_valid)
                    report_mismatch("read_valid", 32'(next_result.read_valid),
                                    32'(m_axis_tuser[0]));
                if (m_axis_tdata[15:0] !== next_result.read_value)
                    report_mismatch("read_value", 32'(next_result.read_value),
                                    32'(m_axis_tdata[15:0]));
                if (m_axis_tuser[1] !== next_result.irq_valid)
                    report_mismatch("irq_valid", 32'(next_result.irq_valid),
                                    32'(m_axis_tuser[1]));
                if (m_axis_tdata[31:16] !== next_result.irq_message)
                    report_mismatch("irq_message", 32'(next_result.irq_message),
                                    32'(m_axis_tdata[31:16]));
            end
        end
    end

    initial begin
        int wait_cycles;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        i_rst_n       = 1'b0;
        error_count   = 0;
        hold_cycles   = 0;
        send_idle_on  = 1'b1;
        recv_idle_on  = 1'b1;
        clk_rate      = '0;
        clk_period    = '0;
        clk_phase     = '0;
        clk_ticks     = '0;
        clk_message   = '0;
        clk_pending   = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_rate_extremes();
        test_interrupts();
        test_ignored_items();
        test_random_traffic();
        test_back_pressure();
        test_tick_count();

        s_axis_tvalid <= 1'b0;
        wait_cycles = 0;
        while (clock_results.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (clock_results.size() == 0 && error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
